/* sv/udvm_pkg.sv */
// Shared types, constants, microcode ROM and operand decode functions for the UDVM operand decoder.
`timescale 1ns / 1ps
`default_nettype none

package udvm_pkg;

    // Machine memory geometry
    localparam int MEM_ADDR_BITS = 16;
    localparam int MEM_SIZE      = 1 << MEM_ADDR_BITS;

    // Operation codes carried in the input tuser
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_SETP   = 2'd1;
    localparam logic [1:0] OP_DECODE = 2'd2;

    // Operand kinds
    localparam logic [1:0] K_LITERAL   = 2'd0;
    localparam logic [1:0] K_REFERENCE = 2'd1;
    localparam logic [1:0] K_MULTITYPE = 2'd2;
    localparam logic [1:0] K_ADDRESS   = 2'd3;

    // Microprogram step addresses
    typedef logic [3:0] step_t;
    localparam step_t S_IDLE   = 4'd0;
    localparam step_t S_WR     = 4'd1;
    localparam step_t S_SETP   = 4'd2;
    localparam step_t S_RD0    = 4'd3;
    localparam step_t S_RD1    = 4'd4;
    localparam step_t S_RD2    = 4'd5;
    localparam step_t S_CAPB2  = 4'd6;
    localparam step_t S_INDCHK = 4'd7;
    localparam step_t S_IND0   = 4'd8;
    localparam step_t S_IND1   = 4'd9;
    localparam step_t S_INDCAP = 4'd10;
    localparam step_t S_FIN    = 4'd11;

    // Memory address source
    typedef enum logic [2:0] {
        A_PTR  = 3'd0,
        A_PTR1 = 3'd1,
        A_PTR2 = 3'd2,
        A_IND  = 3'd3,
        A_IND1 = 3'd4,
        A_TGT  = 3'd5
    } addr_sel_t;

    // Which byte register captures the read data
    typedef enum logic [2:0] {
        CAP_NONE = 3'd0,
        CAP_B0   = 3'd1,
        CAP_B1   = 3'd2,
        CAP_B2   = 3'd3,
        CAP_I0   = 3'd4,
        CAP_I1   = 3'd5
    } cap_t;

    // Execution pointer update
    typedef enum logic [1:0] {
        P_HOLD   = 2'd0,
        P_TARGET = 2'd1,
        P_DECODE = 2'd2
    } ptr_op_t;

    // Sequencing condition
    typedef enum logic [2:0] {
        C_NEXT     = 3'd0,
        C_GOTO     = 3'd1,
        C_DISPATCH = 3'd2,
        C_SKIP_B1  = 3'd3,
        C_SKIP_B2  = 3'd4,
        C_NO_IND   = 3'd5,
        C_WAIT_OUT = 3'd6
    } cond_t;

    // One control word
    typedef struct packed {
        addr_sel_t addr_sel;
        logic      ram_we;
        cap_t      cap;
        ptr_op_t   ptr_op;
        logic      emit;
        cond_t     cond;
        step_t     target;
    } ucode_t;

    // Decode result
    typedef struct packed {
        logic [15:0] val;
        logic [1:0]  len;
        logic        bad;
    } dec_t;

    // Microcode ROM
    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        begin
            w = '{A_PTR, 1'b0, CAP_NONE, P_HOLD, 1'b0, C_GOTO, S_IDLE};
            unique case (s)
                S_IDLE:   w = '{A_PTR,  1'b0, CAP_NONE, P_HOLD,   1'b0, C_DISPATCH, S_IDLE};
                S_WR:     w = '{A_TGT,  1'b1, CAP_NONE, P_HOLD,   1'b0, C_GOTO,     S_IDLE};
                S_SETP:   w = '{A_PTR,  1'b0, CAP_NONE, P_TARGET, 1'b0, C_GOTO,     S_IDLE};
                S_RD0:    w = '{A_PTR,  1'b0, CAP_NONE, P_HOLD,   1'b0, C_NEXT,     S_IDLE};
                S_RD1:    w = '{A_PTR1, 1'b0, CAP_B0,   P_HOLD,   1'b0, C_SKIP_B1,  S_INDCHK};
                S_RD2:    w = '{A_PTR2, 1'b0, CAP_B1,   P_HOLD,   1'b0, C_SKIP_B2,  S_INDCHK};
                S_CAPB2:  w = '{A_PTR,  1'b0, CAP_B2,   P_HOLD,   1'b0, C_NEXT,     S_IDLE};
                S_INDCHK: w = '{A_PTR,  1'b0, CAP_NONE, P_HOLD,   1'b0, C_NO_IND,   S_FIN};
                S_IND0:   w = '{A_IND,  1'b0, CAP_NONE, P_HOLD,   1'b0, C_NEXT,     S_IDLE};
                S_IND1:   w = '{A_IND1, 1'b0, CAP_I0,   P_HOLD,   1'b0, C_NEXT,     S_IDLE};
                S_INDCAP: w = '{A_PTR,  1'b0, CAP_I1,   P_HOLD,   1'b0, C_NEXT,     S_IDLE};
                S_FIN:    w = '{A_PTR,  1'b0, CAP_NONE, P_DECODE, 1'b1, C_WAIT_OUT, S_IDLE};
                default:  w = '{A_PTR,  1'b0, CAP_NONE, P_HOLD,   1'b0, C_GOTO,     S_IDLE};
            endcase
            return w;
        end
    endfunction

    // Dispatch target for an accepted transaction
    function automatic step_t dispatch(input logic [1:0] op);
        step_t t;
        begin
            t = S_IDLE;
            unique case (op)
                OP_WRITE:  t = S_WR;
                OP_SETP:   t = S_SETP;
                OP_DECODE: t = S_RD0;
                default:   t = S_IDLE;
            endcase
            return t;
        end
    endfunction

    function automatic logic is_multi(input logic [1:0] kind);
        return (kind == K_MULTITYPE) || (kind == K_ADDRESS);
    endfunction

    // Second bytecode byte needed
    function automatic logic need_b1(input logic [1:0] kind, input logic [7:0] b);
        logic r;
        begin
            if (!is_multi(kind))
                r = b[7];
            else
                r = (b == 8'h80) || (b == 8'h81) || ((b >= 8'h90) && (b <= 8'hdf));
            return r;
        end
    endfunction

    // Third bytecode byte needed
    function automatic logic need_b2(input logic [1:0] kind, input logic [7:0] b);
        logic r;
        begin
            if (!is_multi(kind))
                r = (b[7:6] == 2'b11);
            else
                r = (b == 8'h80) || (b == 8'h81);
            return r;
        end
    endfunction

    // Indirect multitype forms read a word from memory
    function automatic logic is_indirect(input logic [1:0] kind, input logic [7:0] b);
        return is_multi(kind) &&
               ((b[7:6] == 2'b01) || (b == 8'h81) || (b[7:5] == 3'b110));
    endfunction

    // Address of the indirect word
    function automatic logic [15:0] ind_addr(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2);
        logic [15:0] a;
        begin
            if (b0[7:6] == 2'b01)
                a = {9'd0, b0[5:0], 1'b0};
            else if (b0 == 8'h81)
                a = {b1, b2};
            else
                a = {3'd0, b0[4:0], b1};
            return a;
        end
    endfunction

    // Operand value, length and invalid flag from the captured bytes
    function automatic dec_t decode(input logic [1:0] kind, input logic [7:0] b0,
                                    input logic [7:0] b1, input logic [7:0] b2,
                                    input logic [15:0] iw, input logic [15:0] iaddr);
        dec_t d;
        begin
            d = '{16'd0, 2'd1, 1'b0};
            if (kind == K_LITERAL) begin
                if (!b0[7])
                    d = '{{8'd0, b0}, 2'd1, 1'b0};
                else if (!b0[6])
                    d = '{{2'd0, b0[5:0], b1}, 2'd2, 1'b0};
                else
                    d = '{{b1, b2}, 2'd3, 1'b0};
            end else if (kind == K_REFERENCE) begin
                if (!b0[7])
                    d = '{{7'd0, b0[6:0], 1'b0}, 2'd1, 1'b0};
                else if (!b0[6])
                    d = '{{1'b0, b0[5:0], b1, 1'b0}, 2'd2, 1'b0};
                else
                    d = '{{b1, b2}, 2'd3, 1'b0};
            end else begin
                unique case (b0) inside
                    [8'h00:8'h3f]: d = '{{8'd0, b0}, 2'd1, 1'b0};
                    [8'h40:8'h7f]: d = '{iw, 2'd1, 1'b0};
                    8'h80:         d = '{{b1, b2}, 2'd3, 1'b0};
                    8'h81:         d = '{iw, 2'd3, 1'b0};
                    [8'h82:8'h85]: d = '{16'd0, 2'd0, 1'b1};
                    [8'h86:8'h87]: d = '{(b0[0] ? 16'h0080 : 16'h0040), 2'd1, 1'b0};
                    [8'h88:8'h8f]: d = '{16'h0100 << b0[2:0], 2'd1, 1'b0};
                    [8'h90:8'h9f]: d = '{{4'hf, b0[3:0], b1}, 2'd2, 1'b0};
                    [8'ha0:8'hbf]: d = '{{3'd0, b0[4:0], b1}, 2'd2, 1'b0};
                    [8'hc0:8'hdf]: d = '{iw, 2'd2, 1'b0};
                    default:       d = '{{11'h7ff, b0[4:0]}, 2'd1, 1'b0};
                endcase
                // address operands are relative to the instruction
                if ((kind == K_ADDRESS) && !d.bad)
                    d.val = d.val + iaddr;
            end
            return d;
        end
    endfunction

endpackage

`default_nettype wire

/* sv/udvm_operand_decoder.sv */
// Top level of the UDVM operand decoder: microcoded sequencer, byte memory and output register.
// Usage:
//   Input stream s_axis_*: each transaction writes one memory byte, sets the
//   execution pointer, or decodes one operand at the pointer (operation 3 is
//   dropped). Only decodes produce an output transaction on m_axis_*.
//   A new input transaction is taken only in the idle step, so each one is
//   finished before the next is accepted. A write or pointer set goes straight
//   back to idle; a direct decode reads one, two or three bytecode bytes (an
//   invalid multitype byte reads one), and an indirect form also reads a word.
//   Each step is one word of a small microcode ROM; the single-port byte
//   memory gives one byte per cycle with registered read data. A decode
//   result appears on m_axis_tvalid in the cycle after the final step.
//   The output register holds one result: while it waits the block still takes
//   writes and pointer sets; a decode waits in its final step until the
//   register is free.
//   Reset clears the pointer to zero and empties the output register; memory
//   content is not cleared and must be written before it is decoded.
`timescale 1ns / 1ps
`default_nettype none

module udvm_operand_decoder
    import udvm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [15:0] target_address, [23:16] write_data, [39:24] instruction_address
    input  wire logic [39:0] s_axis_tdata,
    // [1:0] operation, [3:2] operand_kind
    input  wire logic [3:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] decoded_value, [31:16] next_pointer
    output logic [31:0]      m_axis_tdata,
    // [0] invalid_flag
    output logic [0:0]       m_axis_tuser
);

    step_t       step_reg, step_next;
    ucode_t      uw;
    logic [15:0] ptr_reg, ptr_next;
    logic [1:0]  kind_reg;
    logic [15:0] target_reg;
    logic [7:0]  wdata_reg;
    logic [15:0] iaddr_reg;
    logic [7:0]  b0_reg, b1_reg, b2_reg, i0_reg, i1_reg;
    logic [15:0] ind_a;
    logic [15:0] mem_a;
    logic [7:0]  rdata;
    logic        s_accept;
    logic        out_busy;
    logic        emit;
    dec_t        dec;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_bad_reg;

    assign uw            = ucode_rom(step_reg);
    assign s_axis_tready = (step_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_busy      = out_valid_reg && !m_axis_tready;
    assign emit          = uw.emit && !out_busy;
    assign ind_a         = ind_addr(b0_reg, b1_reg, b2_reg);
    assign dec           = decode(kind_reg, b0_reg, b1_reg, b2_reg, {i0_reg, i1_reg}, iaddr_reg);

    // Memory address select
    always_comb
    begin
        case (uw.addr_sel)
            A_PTR:   mem_a = ptr_reg;
            A_PTR1:  mem_a = ptr_reg + 16'd1;
            A_PTR2:  mem_a = ptr_reg + 16'd2;
            A_IND:   mem_a = ind_a;
            A_IND1:  mem_a = ind_a + 16'd1;
            A_TGT:   mem_a = target_reg;
            default: mem_a = ptr_reg;
        endcase
    end

    udvm_ram #(
        .DATA_W (8),
        .DEPTH  (MEM_SIZE)
    ) u_mem (
        .clk   (clk),
        .we    (uw.ram_we),
        .addr  (mem_a[MEM_ADDR_BITS-1:0]),
        .wdata (wdata_reg),
        .rdata (rdata)
    );

    // Sequencer: next step
    always_comb
    begin
        step_next = step_t'(step_reg + 4'd1);
        case (uw.cond)
            C_NEXT:     step_next = step_t'(step_reg + 4'd1);
            C_GOTO:     step_next = uw.target;
            C_DISPATCH: step_next = s_accept ? dispatch(s_axis_tuser[1:0]) : step_reg;
            C_SKIP_B1:  if (!need_b1(kind_reg, rdata)) step_next = uw.target;
            C_SKIP_B2:  if (!need_b2(kind_reg, b0_reg)) step_next = uw.target;
            C_NO_IND:   if (!is_indirect(kind_reg, b0_reg)) step_next = uw.target;
            C_WAIT_OUT: step_next = out_busy ? step_reg : uw.target;
            default:    step_next = S_IDLE;
        endcase
    end

    // Execution pointer update
    always_comb
    begin
        case (uw.ptr_op)
            P_TARGET: ptr_next = target_reg;
            P_DECODE: ptr_next = emit ? (ptr_reg + {14'd0, dec.len}) : ptr_reg;
            default:  ptr_next = ptr_reg;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_IDLE;
            ptr_reg       <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            ptr_reg  <= ptr_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Input fields, captured bytes and result payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            kind_reg   <= s_axis_tuser[3:2];
            target_reg <= s_axis_tdata[15:0];
            wdata_reg  <= s_axis_tdata[23:16];
            iaddr_reg  <= s_axis_tdata[39:24];
        end
        case (uw.cap)
            CAP_B0:  b0_reg <= rdata;
            CAP_B1:  b1_reg <= rdata;
            CAP_B2:  b2_reg <= rdata;
            CAP_I0:  i0_reg <= rdata;
            CAP_I1:  i1_reg <= rdata;
            default: ;
        endcase
        if (emit)
        begin
            out_data_reg <= {ptr_reg + {14'd0, dec.len}, dec.val};
            out_bad_reg  <= dec.bad;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_bad_reg;

    // Pointer moves only in the set-pointer step or at a decode's final step
    a_ptr_src: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(ptr_reg) |-> ($past(step_reg) == S_SETP || $past(step_reg) == S_FIN))
        else $error("execution pointer changed outside set or decode step");

    // A new result always comes from the final decode step
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(step_reg) == S_FIN)
        else $error("result raised outside final decode step");

    // An invalid operand leaves the pointer where it was
    a_bad_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && dec.bad) |=> ptr_reg == $past(ptr_reg))
        else $error("invalid operand moved the execution pointer");

endmodule

`default_nettype wire

/* sv/udvm_ram.sv */
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module udvm_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [DATA_W-1:0]        wdata,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write one entry when enabled; read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire
